### hdl/status_led_pattern_controller_assert.svh
// Assertion macros for the checker file of the LED pattern controller.
// Each macro checks on the rising edge of clock and is disabled while reset is high.
`ifndef STATUS_LED_PATTERN_CONTROLLER_ASSERT_SVH
`define STATUS_LED_PATTERN_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLPC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("status LED controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("status LED controller check failed");

`endif

### hdl/slpc_pkg.sv
package slpc_pkg;

   // One request: the status flags of one 0.1 s tick.
   typedef struct packed {
      logic       red_cmd;
      logic       docked;
      logic [2:0] charge_mask;
      logic       charge_flash;
      logic [1:0] batt_level;
      logic       button_pressed;
      logic       sd_fault;
      logic [1:0] run_mode;
      logic [1:0] link_state;
      logic [1:0] stream_state;
      logic       sync_pending;
      logic       rtc_unset;
   } req_type;

   // One response: the five LED drives, 1 = on.
   typedef struct packed {
      logic lower_green;
      logic lower_yellow;
      logic lower_red;
      logic upper_green;
      logic upper_blue;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_SD_ERROR_ENABLE    = 2'd0,
      CSR_RTC_ERROR_ENABLE   = 2'd1,
      CSR_BT_SUPPORT_ENABLED = 2'd2,
      CSR_SD_SYNC_ENABLED    = 2'd3
   } csr_index_type;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] BATTERY_HIGH = 2'd0;
   localparam logic [1:0] BATTERY_MID  = 2'd1;
   localparam logic [1:0] BATTERY_LOW  = 2'd2;

   localparam logic [1:0] MODE_CONFIGURING = 2'd1;
   localparam int         MODE_SENSING_BIT = 1;

   localparam logic [1:0] LINK_OFF       = 2'd0;
   localparam logic [1:0] LINK_UP        = 2'd2;
   localparam logic [1:0] LINK_CONNECTED = 2'd3;

   localparam int STREAM_BT_BIT = 0;
   localparam int STREAM_SD_BIT = 1;

   localparam logic [5:0] SLOW_LAST         = 6'd49;
   localparam logic [4:0] FAST_LAST         = 5'd19;
   localparam logic [4:0] FAST_HALF         = 5'd10;
   localparam logic [4:0] BLUE_PULSE_FIRST  = 5'd12;
   localparam logic [4:0] BLUE_PULSE_SECOND = 5'd14;
   localparam logic [7:0] FAULT_RELOAD      = 8'd255;

endpackage

### hdl/status_led_pattern_controller.sv
// Status LED pattern controller.
// The request channel (req_valid, req_stall, req_data) carries one status tick,
// normally one every 0.1 s. The response channel (rsp_valid, rsp_stall, rsp_data)
// returns exactly one set of five LED levels for every request, in order.
// A request is taken on a rising edge with valid high and stall low.
// The response is registered: it is held in an output register from the
// edge that accepts the request. One request can be taken every cycle; the
// single output register is the only buffering, so while a response sits
// stalled, req_stall is high and further requests wait.
// The APB-style port (csr_*) holds four enable bits at byte addresses 0, 4, 8
// and 12; it should only be written while no request is in flight.
// Synchronous reset turns all LEDs off, clears the blink and fault counters
// and the enable bits, and empties the output register.
module status_led_pattern_controller
   import slpc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic          sd_error_enable_ff;
   logic          rtc_error_enable_ff;
   logic          bt_support_enabled_ff;
   logic          sd_sync_enabled_ff;
   csr_index_type csr_index;
   logic          csr_write;

   rsp_type       led_levels_ff;
   rsp_type       led_levels_in;
   logic [5:0]    slow_count_ff;
   logic [5:0]    slow_count_in;
   logic [4:0]    fast_count_ff;
   logic [4:0]    fast_count_in;
   logic          alternate_pick_ff;
   logic          alternate_pick_in;
   logic [7:0]    fault_count_ff;
   logic [7:0]    fault_count_in;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_data_ff;
   logic          req_accept;

   logic          sensing;
   logic          configuring;
   logic          tick_1s;
   logic          stream_bt;
   logic          stream_sd;
   logic          yellow;

   // Configuration port.
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_error_enable_ff    <= 1'b0;
         rtc_error_enable_ff   <= 1'b0;
         bt_support_enabled_ff <= 1'b0;
         sd_sync_enabled_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SD_ERROR_ENABLE:    sd_error_enable_ff    <= csr_pwdata[0];
            CSR_RTC_ERROR_ENABLE:   rtc_error_enable_ff   <= csr_pwdata[0];
            CSR_BT_SUPPORT_ENABLED: bt_support_enabled_ff <= csr_pwdata[0];
            CSR_SD_SYNC_ENABLED:    sd_sync_enabled_ff    <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         CSR_SD_ERROR_ENABLE:    csr_prdata[0] = sd_error_enable_ff;
         CSR_RTC_ERROR_ENABLE:   csr_prdata[0] = rtc_error_enable_ff;
         CSR_BT_SUPPORT_ENABLED: csr_prdata[0] = bt_support_enabled_ff;
         CSR_SD_SYNC_ENABLED:    csr_prdata[0] = sd_sync_enabled_ff;
      endcase
   end

   // Handshake: the output register can be refilled in the cycle it is taken.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign sensing     = req_data.run_mode[MODE_SENSING_BIT];
   assign configuring = (req_data.run_mode == MODE_CONFIGURING);
   assign tick_1s     = (fast_count_ff == '0) || (fast_count_ff == FAST_HALF);
   assign stream_bt   = req_data.stream_state[STREAM_BT_BIT];
   assign stream_sd   = req_data.stream_state[STREAM_SD_BIT];

   // Pattern decision for one tick.
   always_comb begin
      led_levels_in     = led_levels_ff;
      fault_count_in    = fault_count_ff;
      alternate_pick_in = alternate_pick_ff;
      yellow            = 1'b0;

      // Lower LEDs.
      priority if (req_data.red_cmd) begin
         led_levels_in.lower_green  = 1'b0;
         led_levels_in.lower_yellow = 1'b0;
         led_levels_in.lower_red    = 1'b1;
      end else if (req_data.docked) begin
         // Toggling a freshly cleared set lights the same LEDs as the solid display.
         led_levels_in.lower_green  = req_data.charge_mask[0];
         led_levels_in.lower_yellow = req_data.charge_mask[1];
         led_levels_in.lower_red    = req_data.charge_mask[2];
      end else begin
         led_levels_in.lower_green  = (slow_count_ff == '0) &&
                                      (req_data.batt_level == BATTERY_HIGH);
         led_levels_in.lower_yellow = (slow_count_ff == '0) &&
                                      (req_data.batt_level == BATTERY_MID);
         led_levels_in.lower_red    = (slow_count_ff == '0) &&
                                      (req_data.batt_level == BATTERY_LOW);
      end

      if (req_data.button_pressed) begin
         led_levels_in.lower_green = 1'b1;
      end

      if (!req_data.docked && req_data.sd_fault && sd_error_enable_ff) begin
         if (fault_count_ff != '0) begin
            fault_count_in = fault_count_ff - 8'd1;
            yellow         = fault_count_in[0];
         end else begin
            fault_count_in = FAULT_RELOAD;
            yellow         = 1'b1;
         end
         led_levels_in.lower_yellow = yellow;
         led_levels_in.lower_red    = !yellow;
      end

      // Upper LEDs.
      priority if (req_data.rtc_unset && rtc_error_enable_ff && !sensing) begin
         led_levels_in.upper_green = !led_levels_ff.upper_green;
         led_levels_in.upper_blue  = led_levels_ff.upper_green;
      end else if (bt_support_enabled_ff && !sd_sync_enabled_ff) begin
         priority if (!sensing) begin
            priority if (configuring) begin
               led_levels_in.upper_green = !led_levels_ff.upper_green;
            end else if (req_data.link_state == LINK_CONNECTED) begin
               led_levels_in.upper_blue  = 1'b1;
               led_levels_in.upper_green = 1'b0;
            end else if (req_data.link_state == LINK_UP) begin
               led_levels_in.upper_blue  = !led_levels_ff.upper_blue;
               led_levels_in.upper_green = 1'b0;
            end else begin
               led_levels_in.upper_blue  = (fast_count_ff == '0);
               led_levels_in.upper_green = 1'b0;
            end
         end else if (stream_bt && !stream_sd) begin
            led_levels_in.upper_blue  = led_levels_ff.upper_blue ^ tick_1s;
            led_levels_in.upper_green = 1'b0;
         end else if (!stream_bt && stream_sd) begin
            led_levels_in.upper_green = led_levels_ff.upper_green ^ tick_1s;
            led_levels_in.upper_blue  = 1'b0;
         end else if (stream_bt && stream_sd) begin
            // Streaming and logging together: one LED at a time, alternating.
            if (tick_1s) begin
               if (led_levels_ff.upper_blue || led_levels_ff.upper_green) begin
                  led_levels_in.upper_blue  = 1'b0;
                  led_levels_in.upper_green = 1'b0;
               end else begin
                  led_levels_in.upper_blue  = alternate_pick_ff;
                  led_levels_in.upper_green = !alternate_pick_ff;
                  alternate_pick_in         = !alternate_pick_ff;
               end
            end
         end else begin
            led_levels_in.upper_blue  = 1'b0;
            led_levels_in.upper_green = 1'b0;
         end
      end else begin
         priority if (sensing) begin
            led_levels_in.upper_green = (fast_count_ff < FAST_HALF);
         end else if (configuring) begin
            led_levels_in.upper_green = !led_levels_ff.upper_green;
         end else begin
            led_levels_in.upper_green = (fast_count_ff == '0);
         end

         priority if (req_data.link_state == LINK_CONNECTED) begin
            led_levels_in.upper_blue = !led_levels_ff.upper_blue;
         end else if (req_data.sync_pending && sensing && sd_sync_enabled_ff) begin
            led_levels_in.upper_blue = 1'b1;
         end else begin
            led_levels_in.upper_blue = (req_data.link_state != LINK_OFF) &&
               ((fast_count_ff == BLUE_PULSE_FIRST) || (fast_count_ff == BLUE_PULSE_SECOND));
         end
      end
   end

   assign slow_count_in = (slow_count_ff >= SLOW_LAST) ? '0 : slow_count_ff + 6'd1;
   assign fast_count_in = (fast_count_ff >= FAST_LAST) ? '0 : fast_count_ff + 5'd1;

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_levels_ff     <= '0;
         slow_count_ff     <= '0;
         fast_count_ff     <= '0;
         alternate_pick_ff <= 1'b0;
         fault_count_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            led_levels_ff     <= led_levels_in;
            slow_count_ff     <= slow_count_in;
            fast_count_ff     <= fast_count_in;
            alternate_pick_ff <= alternate_pick_in;
            fault_count_ff    <= fault_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= led_levels_in;
      end
   end

endmodule

### hdl/slpc_checker.sv
`include "status_led_pattern_controller_assert.svh"

module slpc_checker
   import slpc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input req_type                   req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rsp_type                   rsp_data,
   input logic                      csr_pready
);

   logic req_accept;
   logic red_only;

   assign req_accept = req_valid && !req_stall;
   assign red_only   = req_data.red_cmd && !req_data.docked && !req_data.sd_fault &&
                       !req_data.button_pressed;

   // A stalled response stays valid with the same LED levels.
   `SLPC_ASSERT_NEXT(rsp_hold_a, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Every accepted request shows its response on the next cycle.
   `SLPC_ASSERT_NEXT(rsp_follows_req_a, req_accept, rsp_valid)

   // A forced red command with no fault or button lights lower red alone.
   `SLPC_ASSERT_NEXT(red_cmd_a, req_accept && red_only,
      rsp_data.lower_red && !rsp_data.lower_green && !rsp_data.lower_yellow)

   // Leaving reset, no response is pending and the port is ready.
   `SLPC_ASSERT_SAME(reset_empty_a, $past(reset), !rsp_valid && csr_pready)

endmodule

bind status_led_pattern_controller slpc_checker u_slpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_data   (req_data),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

### sim/led_pattern_checker.sv
`timescale 1ns / 1ps

module led_pattern_checker
   import slpc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic                      csr_pready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output int                        pending_count,
   output int                        error_count
);

   localparam int LG = 0;
   localparam int LY = 1;
   localparam int LR = 2;
   localparam int UG = 3;
   localparam int UB = 4;

   logic [4:0] led_state;
   logic [5:0] slow_count;
   logic [4:0] fast_count;
   logic       pick_blue;
   logic [7:0] fault_count;

   logic sd_error_en;
   logic rtc_error_en;
   logic bt_en;
   logic sd_sync_en;

   rsp_type expected_leds[$];
   int      mismatches = 0;

   // Works out the LED levels for one status tick and advances the counters.
   task automatic step_leds(input req_type s, output rsp_type r);
      logic [4:0] lv;
      logic       yellow;
      logic       sensing;
      logic       configuring;
      logic       stream_bt;
      logic       stream_sd;
      logic       second_tick;
      logic       g;
      lv = led_state;

      if (s.red_cmd) begin
         lv[LG] = 1'b0;
         lv[LY] = 1'b0;
         lv[LR] = 1'b1;
      end else if (s.docked) begin
         // The toggle acts on freshly cleared bits, so it lights the mask as well.
         lv[2:0] = 3'b000;
         if (s.charge_flash)
            lv[2:0] = lv[2:0] ^ s.charge_mask;
         else
            lv[2:0] = lv[2:0] | s.charge_mask;
      end else begin
         lv[2:0] = 3'b000;
         if (slow_count == 6'd0) begin
            case (s.batt_level)
               BATTERY_HIGH: lv[LG] = 1'b1;
               BATTERY_MID:  lv[LY] = 1'b1;
               BATTERY_LOW:  lv[LR] = 1'b1;
               default:      ;
            endcase
         end
      end
      if (s.button_pressed)
         lv[LG] = 1'b1;
      if (!s.docked && s.sd_fault && sd_error_en) begin
         if (fault_count != 8'd0) begin
            fault_count = fault_count - 8'd1;
            yellow      = fault_count[0];
         end else begin
            fault_count = FAULT_RELOAD;
            yellow      = 1'b1;
         end
         lv[LY] = yellow;
         lv[LR] = !yellow;
      end

      sensing     = s.run_mode[MODE_SENSING_BIT];
      configuring = (s.run_mode == MODE_CONFIGURING);
      stream_bt   = s.stream_state[STREAM_BT_BIT];
      stream_sd   = s.stream_state[STREAM_SD_BIT];
      second_tick = (fast_count == 5'd0) || (fast_count == FAST_HALF);

      if (s.rtc_unset && rtc_error_en && !sensing) begin
         g      = lv[UG];
         lv[UG] = !g;
         lv[UB] = g;
      end else if (bt_en && !sd_sync_en) begin
         if (!sensing) begin
            if (configuring) begin
               lv[UG] = !lv[UG];
            end else begin
               lv[UG] = 1'b0;
               if (s.link_state == LINK_CONNECTED)
                  lv[UB] = 1'b1;
               else if (s.link_state == LINK_UP)
                  lv[UB] = !lv[UB];
               else
                  lv[UB] = (fast_count == 5'd0);
            end
         end else if (stream_bt && !stream_sd) begin
            if (second_tick)
               lv[UB] = !lv[UB];
            lv[UG] = 1'b0;
         end else if (!stream_bt && stream_sd) begin
            if (second_tick)
               lv[UG] = !lv[UG];
            lv[UB] = 1'b0;
         end else if (stream_bt && stream_sd) begin
            // Both ready: blank, then light green and blue in turn.
            if (second_tick) begin
               if (lv[UB] || lv[UG]) begin
                  lv[UB] = 1'b0;
                  lv[UG] = 1'b0;
               end else begin
                  if (pick_blue)
                     lv[UB] = 1'b1;
                  else
                     lv[UG] = 1'b1;
                  pick_blue = !pick_blue;
               end
            end
         end else begin
            lv[UG] = 1'b0;
            lv[UB] = 1'b0;
         end
      end else begin
         if (!sensing) begin
            if (configuring)
               lv[UG] = !lv[UG];
            else
               lv[UG] = (fast_count == 5'd0);
         end else begin
            lv[UG] = (fast_count < FAST_HALF);
         end
         if (s.link_state == LINK_CONNECTED)
            lv[UB] = !lv[UB];
         else if (s.sync_pending && sensing && sd_sync_en)
            lv[UB] = 1'b1;
         else
            lv[UB] = (s.link_state != LINK_OFF) &&
                     (fast_count == BLUE_PULSE_FIRST || fast_count == BLUE_PULSE_SECOND);
      end

      led_state  = lv;
      slow_count = (slow_count >= SLOW_LAST) ? 6'd0 : slow_count + 6'd1;
      fast_count = (fast_count >= FAST_LAST) ? 5'd0 : fast_count + 5'd1;

      r.lower_green  = lv[LG];
      r.lower_yellow = lv[LY];
      r.lower_red    = lv[LR];
      r.upper_green  = lv[UG];
      r.upper_blue   = lv[UB];
   endtask

   task automatic compare_led(input string led_name, input logic want, input logic got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0b actual %0b", $realtime, led_name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type wanted;
      if (reset) begin
         led_state    = 5'd0;
         slow_count   = 6'd0;
         fast_count   = 5'd0;
         pick_blue    = 1'b0;
         fault_count  = 8'd0;
         sd_error_en  = 1'b0;
         rtc_error_en = 1'b0;
         bt_en        = 1'b0;
         sd_sync_en   = 1'b0;
         expected_leds.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[3:2]))
               CSR_SD_ERROR_ENABLE:    sd_error_en  = csr_pwdata[0];
               CSR_RTC_ERROR_ENABLE:   rtc_error_en = csr_pwdata[0];
               CSR_BT_SUPPORT_ENABLED: bt_en        = csr_pwdata[0];
               CSR_SD_SYNC_ENABLED:    sd_sync_en   = csr_pwdata[0];
               default:                ;
            endcase
         end
         if (req_valid && !req_stall) begin
            step_leds(req_data, predicted);
            expected_leds.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_leds.size() == 0) begin
               mismatches++;
               $display("%0t: LED response with no request pending, expected none actual %b",
                        $realtime, rsp_data);
            end else begin
               wanted = expected_leds.pop_front();
               compare_led("lower_green", wanted.lower_green, rsp_data.lower_green);
               compare_led("lower_yellow", wanted.lower_yellow, rsp_data.lower_yellow);
               compare_led("lower_red", wanted.lower_red, rsp_data.lower_red);
               compare_led("upper_green", wanted.upper_green, rsp_data.upper_green);
               compare_led("upper_blue", wanted.upper_blue, rsp_data.upper_blue);
            end
         end
      end
      pending_count <= expected_leds.size();
      error_count   <= mismatches;
   end

endmodule

### sim/status_led_pattern_controller_tb.sv
`timescale 1ns / 1ps

module status_led_pattern_controller_tb;
   import slpc_pkg::*;

   localparam int PHASES     = 12;
   localparam int PHASE_TICKS = 157;
   localparam int LONG_HOLD  = 60;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   req_type                   req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic long_hold     = 1'b0;
   event hold_trigger;
   int   pending_count;
   int   error_count;

   always #5 clock = ~clock;

   status_led_pattern_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   led_pattern_checker u_led_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);
   end

   // Long receiver hold-off so that the output register fills and the input stalls.
   initial begin
      forever begin
         @(hold_trigger);
         long_hold <= 1'b1;
         repeat (LONG_HOLD) @(posedge clock);
         long_hold <= 1'b0;
      end
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_tick(input req_type t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      // Stall is settled by the falling edge, ahead of the edge that takes the request.
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic bit_value);
      logic [31:0] noise;
      noise       = $urandom;
      noise[0]    = bit_value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= noise[CSR_DATA_WIDTH-1:0];
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Bit order: sd_sync, bt_support, rtc_error, sd_error.
   task automatic apply_settings(input logic [3:0] enables);
      write_csr(CSR_SD_ERROR_ENABLE, enables[0]);
      write_csr(CSR_RTC_ERROR_ENABLE, enables[1]);
      write_csr(CSR_BT_SUPPORT_ENABLED, enables[2]);
      write_csr(CSR_SD_SYNC_ENABLED, enables[3]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic req_type random_status();
      req_type     s;
      logic [31:0] noise;
      noise            = $urandom;
      s                = noise[$bits(req_type)-1:0];
      // Keep the overriding flags rare so the battery blink and fault flash show.
      s.red_cmd        = ($urandom_range(0, 7) == 0);
      s.docked         = ($urandom_range(0, 3) == 0);
      s.button_pressed = ($urandom_range(0, 5) == 0);
      return s;
   endfunction

   // Status flags mostly hold steady for a while, as on a real device, so the
   // blink counters and the fault countdown get to run through their patterns.
   task automatic random_ticks(input int count);
      req_type                    base;
      req_type                    t;
      logic [$bits(req_type)-1:0] raw;
      int                         left;
      int                         run_len;
      left = count;
      while (left > 0) begin
         base    = random_status();
         run_len = $urandom_range(1, 40);
         while (run_len > 0 && left > 0) begin
            t = base;
            case ($urandom_range(0, 9))
               0: t = random_status();
               1, 2: begin
                  raw = t;
                  raw[$urandom_range(0, $bits(req_type) - 1)] ^= 1'b1;
                  t = raw;
               end
               default: ;
            endcase
            send_tick(t);
            run_len--;
            left--;
         end
      end
   endtask

   initial begin
      req_type    t;
      logic [3:0] enables;
      int         phase;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_settings(4'b0111);
      t = '0;
      send_tick(t);
      t = '1;
      send_tick(t);
      t = '0;
      t.red_cmd = 1'b1;
      t.button_pressed = 1'b1;
      send_tick(t);
      t = '0;
      t.docked = 1'b1;
      t.charge_mask = 3'b111;
      send_tick(t);
      t.charge_flash = 1'b1;
      t.charge_mask = 3'b101;
      repeat (2) send_tick(t);
      t = '0;
      t.sd_fault = 1'b1;
      t.batt_level = 2'b11;
      repeat (3) send_tick(t);
      t.docked = 1'b1;
      send_tick(t);
      t = '0;
      t.rtc_unset = 1'b1;
      repeat (2) send_tick(t);
      // Run mode with both bits set counts as sensing, never configuring.
      t.run_mode = MODE_CONFIGURING;
      t.run_mode[MODE_SENSING_BIT] = 1'b1;
      send_tick(t);
      t = '0;
      t.run_mode = MODE_CONFIGURING;
      send_tick(t);
      t = '0;
      t.link_state = LINK_CONNECTED;
      send_tick(t);
      t.link_state = LINK_UP;
      repeat (2) send_tick(t);
      t = '0;
      t.run_mode[MODE_SENSING_BIT] = 1'b1;
      t.stream_state[STREAM_BT_BIT] = 1'b1;
      send_tick(t);
      t.stream_state[STREAM_SD_BIT] = 1'b1;
      repeat (4) send_tick(t);
      t.stream_state[STREAM_BT_BIT] = 1'b0;
      send_tick(t);
      t.sync_pending = 1'b1;
      send_tick(t);
      wait_drained();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 67;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 67;
            end
            default: begin
               send_idle_pct = 30;
               stall_pct     = 30;
            end
         endcase
         case (phase)
            0:       enables = 4'b0000;
            1:       enables = 4'b1111;
            2:       enables = 4'b0111;
            3:       enables = 4'b1011;
            default: enables = $urandom_range(0, 15);
         endcase
         apply_settings(enables);
         if (phase == 0 || phase == 4)
            -> hold_trigger;
         random_ticks(PHASE_TICKS);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/slpc_pkg.sv
hdl/status_led_pattern_controller.sv
hdl/slpc_checker.sv
sim/led_pattern_checker.sv
sim/status_led_pattern_controller_tb.sv
